// ----- rtl/tcnd_pkg.sv -----
package tcnd_pkg;

  // default geometry
  localparam int TAPS_DEF  = 24;
  localparam int NOTES_DEF = 7;

  // field widths fixed by the interface
  localparam int SAMPLE_W = 8;
  localparam int COEF_W   = 8;
  localparam int SCORE_W  = 20;
  localparam int NOTE_W   = 3;
  localparam int LED_W    = 6;
  localparam int SEL_W    = 3;
  localparam int TAP_W    = 5;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_OFFSET    = 1'b1;

  // register reset values
  localparam int THRESHOLD_RESET = 10000;
  localparam int OFFSET_RESET    = 114;

  // score saturation limits
  localparam int SCORE_MAX = 524287;
  localparam int SCORE_MIN = -524288;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // led codes for the first three notes
  localparam logic [LED_W-1:0] LED_A    = 6'h20;
  localparam logic [LED_W-1:0] LED_B    = 6'h10;
  localparam logic [LED_W-1:0] LED_C    = 6'h08;
  localparam logic [LED_W-1:0] LED_NONE = 6'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TPL_RD,
    ST_TPL_WR,
    ST_SAMPLE_WR,
    ST_MAC,
    ST_PICK,
    ST_OUT
  } state_t;

  function automatic logic [LED_W-1:0] led_code(input int unsigned k);
    logic [LED_W-1:0] led;
    unique case (k)
      0:       led = LED_A;
      1:       led = LED_B;
      2:       led = LED_C;
      default: led = LED_NONE;
    endcase
    return led;
  endfunction

endpackage

// ----- rtl/tcnd_ram.sv -----
module tcnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/template_correlation_note_detector_top.sv -----
// Template correlation note detector. Each sample transfer (func 0) subtracts the
// offset register from the raw reading, stores the wrapped signed byte in a
// TAPS-entry ring memory and correlates the ring against NOTES templates held in a
// second memory, one row per tap with all notes side by side, so NOTES multiply-adds
// run in parallel and one tap is consumed per cycle. A sample is taken in the idle
// state, then passes through one ring write, TAPS reads plus the read latency of the
// ring and template memories, a winner search over the notes one at a time, and the
// load of the result register, which waits while an earlier result is still stalled.
// A template load transfer (func 1) is a read-modify-write of one template row; it
// gives no result. Both memories read as zero after reset through per-row valid
// flags, so no clearing pass is needed. Only one item is in flight; a finished result
// waits in the output register while the next input is taken.
module template_correlation_note_detector_top #(
  parameter int TAPS  = tcnd_pkg::TAPS_DEF,
  parameter int NOTES = tcnd_pkg::NOTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [tcnd_pkg::SAMPLE_W-1:0]  raw_sample,
  input  logic [tcnd_pkg::SEL_W-1:0]     template_select,
  input  logic [tcnd_pkg::TAP_W-1:0]     tap_select,
  input  logic signed [tcnd_pkg::COEF_W-1:0] coefficient,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcnd_pkg::NOTE_W-1:0]    note,
  output logic signed [tcnd_pkg::SCORE_W-1:0] score,
  output logic [tcnd_pkg::LED_W-1:0]     led_pattern,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcnd_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcnd_pkg::PDATA_W-1:0]   pwdata,
  output logic [tcnd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import tcnd_pkg::*;

  localparam int TA     = $clog2(TAPS);
  localparam int NW     = $clog2(NOTES);
  localparam int SUM_W  = TA + 2 * COEF_W;
  localparam int ACC_W  = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;
  localparam int ROW_W  = NOTES * COEF_W;
  localparam logic [TA-1:0] LAST_SLOT = TA'(TAPS - 1);
  localparam logic [TA:0]   MAC_END   = (TA + 1)'(TAPS);
  localparam logic [NW-1:0] LAST_NOTE = NW'(NOTES - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(SCORE_MAX);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(SCORE_MIN);

  // configuration registers
  logic signed [SCORE_W-1:0]  threshold;
  logic        [SAMPLE_W-1:0] sample_offset;

  // control and item registers
  state_t state, state_next;
  logic [TA-1:0]      newest;
  logic [TA-1:0]      rd_slot;
  logic [TA:0]        mac_cnt;
  logic               mac_live;
  logic               ring_ok;
  logic               tpl_ok;
  logic [TAPS-1:0]    ring_valid;
  logic [TAPS-1:0]    tpl_valid;
  logic [SAMPLE_W-1:0] sample_q;
  logic [TA-1:0]      tap_q;
  logic [SEL_W-1:0]   sel_q;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [ACC_W-1:0] acc [NOTES];
  logic [NW-1:0]      pick_k;
  logic               have_later;
  logic signed [ACC_W-1:0] later_max;
  logic               found;
  logic [NW-1:0]      best_k;
  logic signed [ACC_W-1:0] best_sum;

  // memory ports
  logic               ring_we;
  logic [TA-1:0]      ring_raddr;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic               tpl_we;
  logic [TA-1:0]      tpl_raddr;
  logic [ROW_W-1:0]   tpl_rdata;
  logic [ROW_W-1:0]   tpl_wdata;

  // control decodes
  logic in_take;
  logic load_ok;
  logic cfg_wr;
  logic mac_issue;
  logic out_free;
  logic signed [ACC_W-1:0] thr_ext;
  logic signed [ACC_W-1:0] cur_sum;
  logic win;
  logic signed [ACC_W-1:0] sat_sum;

  assign in_take  = in_valid && !in_stall;
  assign load_ok  = ({1'b0, template_select} < (SEL_W + 1)'(NOTES)) &&
                    ({1'b0, tap_select} < (TAP_W + 1)'(TAPS));
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid || !out_stall;
  assign thr_ext  = ACC_W'(threshold);
  assign cur_sum  = acc[pick_k];
  assign win      = (cur_sum > thr_ext) && (!have_later || (cur_sum > later_max));

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = PDATA_W'(threshold);
      REG_OFFSET:    prdata = PDATA_W'(sample_offset);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= SCORE_W'(THRESHOLD_RESET);
      sample_offset <= SAMPLE_W'(OFFSET_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: threshold     <= pwdata[SCORE_W-1:0];
        REG_OFFSET:    sample_offset <= pwdata[SAMPLE_W-1:0];
        default:       ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_SAMPLE) begin
            state_next = ST_SAMPLE_WR;
          end else if (load_ok) begin
            state_next = ST_TPL_RD;
          end
        end
      end
      ST_TPL_RD:    state_next = ST_TPL_WR;
      ST_TPL_WR:    state_next = ST_IDLE;
      ST_SAMPLE_WR: state_next = ST_MAC;
      ST_MAC: begin
        if (mac_cnt == MAC_END) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_k == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    ring_we    = 1'b0;
    tpl_we     = 1'b0;
    mac_issue  = 1'b0;
    ring_raddr = rd_slot;
    tpl_raddr  = mac_cnt[TA-1:0];
    unique case (state)
      ST_IDLE:      in_stall  = 1'b0;
      ST_TPL_RD:    tpl_raddr = tap_q;
      ST_TPL_WR:    tpl_we    = 1'b1;
      ST_SAMPLE_WR: ring_we   = 1'b1;
      ST_MAC:       mac_issue = (mac_cnt != MAC_END);
      ST_PICK:      ;
      ST_OUT:       ;
      default:      ;
    endcase
  end

  // template row merge: replace one note's lane of the row
  always_comb begin
    tpl_wdata = tpl_valid[tap_q] ? tpl_rdata : '0;
    for (int n = 0; n < NOTES; n++) begin
      if (sel_q == SEL_W'(n)) begin
        tpl_wdata[n*COEF_W +: COEF_W] = coef_q;
      end
    end
  end

  // sum saturated to the score range
  always_comb begin
    if (best_sum > SAT_MAX) begin
      sat_sum = SAT_MAX;
    end else if (best_sum < SAT_MIN) begin
      sat_sum = SAT_MIN;
    end else begin
      sat_sum = best_sum;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      newest     <= LAST_SLOT;
      ring_valid <= '0;
      tpl_valid  <= '0;
      mac_live   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      mac_live <= mac_issue;
      if (in_take && (func == FUNC_SAMPLE)) begin
        newest <= (newest == LAST_SLOT) ? '0 : newest + 1'b1;
      end
      if (ring_we) begin
        ring_valid[newest] <= 1'b1;
      end
      if (tpl_we) begin
        tpl_valid[tap_q] <= 1'b1;
      end
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_q <= raw_sample - sample_offset;
      tap_q    <= TA'(tap_select);
      sel_q    <= template_select;
      coef_q   <= coefficient;
    end

    // start of correlation
    if (state == ST_SAMPLE_WR) begin
      rd_slot <= newest;
      mac_cnt <= '0;
      for (int n = 0; n < NOTES; n++) begin
        acc[n] <= '0;
      end
    end

    // tap reads, one per cycle, walking the ring from the newest slot
    if (mac_issue) begin
      rd_slot <= (rd_slot == LAST_SLOT) ? '0 : rd_slot + 1'b1;
      mac_cnt <= mac_cnt + 1'b1;
      ring_ok <= ring_valid[rd_slot];
      tpl_ok  <= tpl_valid[mac_cnt[TA-1:0]];
    end

    // one multiply-add per note on the data read last cycle
    if (mac_live) begin
      for (int n = 0; n < NOTES; n++) begin
        acc[n] <= acc[n] + ACC_W'(
          $signed(tpl_ok ? tpl_rdata[n*COEF_W +: COEF_W] : {COEF_W{1'b0}}) *
          $signed(ring_ok ? ring_rdata : {SAMPLE_W{1'b0}}));
      end
    end

    // winner search from the last note down to the first
    if ((state == ST_MAC) && (mac_cnt == MAC_END)) begin
      pick_k     <= LAST_NOTE;
      have_later <= 1'b0;
      found      <= 1'b0;
      best_k     <= '0;
      best_sum   <= '0;
    end
    if (state == ST_PICK) begin
      pick_k     <= pick_k - 1'b1;
      have_later <= 1'b1;
      if (!have_later || (cur_sum > later_max)) begin
        later_max <= cur_sum;
      end
      if (win) begin
        found    <= 1'b1;
        best_k   <= pick_k;
        best_sum <= cur_sum;
      end
    end

    // result register
    if ((state == ST_OUT) && out_free) begin
      if (found) begin
        note        <= NOTE_W'(best_k) + 1'b1;
        score       <= sat_sum[SCORE_W-1:0];
        led_pattern <= led_code(32'(best_k));
      end else begin
        note        <= '0;
        score       <= '0;
        led_pattern <= LED_NONE;
      end
    end
  end

  // sample ring memory
  tcnd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (newest),
    .wdata (sample_q),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // template memory, one row per tap holding every note's coefficient
  tcnd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TAPS)
  ) u_tpl_ram (
    .clk   (clk),
    .we    (tpl_we),
    .waddr (tap_q),
    .wdata (tpl_wdata),
    .raddr (tpl_raddr),
    .rdata (tpl_rdata)
  );

endmodule
